[src/source_text_tokenizer_macros.svh]
// assertion macros used by the tokenizer checker
`ifndef SOURCE_TEXT_TOKENIZER_MACROS_SVH
`define SOURCE_TEXT_TOKENIZER_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define STT_ASSERT_IMP(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while reset is asserted
`define STT_ASSERT_NXT(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/stt_pkg.sv]
// types, token codes and character tables for the source text tokenizer
package stt_pkg;

	localparam int FIELD_BITS = 24;
	localparam int LINE_BITS  = 24;
	localparam int KIND_BITS  = 6;
	localparam int OUTQ_DEPTH = 4;

	localparam logic [LINE_BITS-1:0] LINE_RESET = 24'd1;
	localparam logic [LINE_BITS-1:0] LINE_MAX   = 24'hFFFFFF;

	// token kinds
	localparam logic [KIND_BITS-1:0] KIND_OP_BASE   = 6'd9;
	localparam logic [KIND_BITS-1:0] KIND_OPEQ_BASE = 6'd10;
	localparam logic [KIND_BITS-1:0] KIND_AND       = 6'd27;
	localparam logic [KIND_BITS-1:0] KIND_OR        = 6'd28;
	localparam logic [KIND_BITS-1:0] KIND_NUMBER    = 6'd29;
	localparam logic [KIND_BITS-1:0] KIND_IDENT     = 6'd30;
	localparam logic [KIND_BITS-1:0] KIND_BOOL      = 6'd31;
	localparam logic [KIND_BITS-1:0] KIND_FN        = 6'd32;
	localparam logic [KIND_BITS-1:0] KIND_LET       = 6'd33;
	localparam logic [KIND_BITS-1:0] KIND_MUT       = 6'd34;
	localparam logic [KIND_BITS-1:0] KIND_RETURN    = 6'd35;
	localparam logic [KIND_BITS-1:0] KIND_END       = 6'd36;
	localparam logic [KIND_BITS-1:0] KIND_ERROR     = 6'd37;

	// operator indexes held while waiting for a second character
	localparam logic [3:0] OP_NONE     = 4'd0;
	localparam logic [3:0] OP_EQ_FORMS = 4'd9;
	localparam logic [3:0] OP_SLASH    = 4'd5;
	localparam logic [3:0] OP_AMP      = 4'd9;
	localparam logic [3:0] OP_PIPE     = 4'd10;

	// characters with a role of their own
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_PIPE   = 8'h7C;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LZ     = 8'h7A;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UZ     = 8'h5A;
	localparam logic [7:0] CH_USCORE = 8'h5F;

	// keywords, text right-aligned, last character lowest
	localparam int NUM_KW = 6;
	localparam logic [47:0] KW_TEXT [NUM_KW] = '{
		48'h0000_0000_666E,  // fn
		48'h0000_006C_6574,  // let
		48'h0000_006D_7574,  // mut
		48'h7265_7475_726E,  // return
		48'h0000_7472_7565,  // true
		48'h0066_616C_7365   // false
	};
	localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd2, 3'd3, 3'd3, 3'd6, 3'd4, 3'd5};
	localparam logic [KIND_BITS-1:0] KW_KIND [NUM_KW] = '{
		KIND_FN, KIND_LET, KIND_MUT, KIND_RETURN, KIND_BOOL, KIND_BOOL
	};

	typedef enum logic [7:0] {
		MODE_IDLE    = 8'b0000_0001,
		MODE_OP      = 8'b0000_0010,
		MODE_INT     = 8'b0000_0100,
		MODE_DOT     = 8'b0000_1000,
		MODE_FRAC    = 8'b0001_0000,
		MODE_WORD    = 8'b0010_0000,
		MODE_COMMENT = 8'b0100_0000,
		MODE_HALT    = 8'b1000_0000
	} mode_t;

	typedef struct packed {
		logic [KIND_BITS-1:0]  kind;
		logic [FIELD_BITS-1:0] start;
		logic [FIELD_BITS-1:0] len;
		logic [LINE_BITS-1:0]  line;
		logic                  last;
	} tok_t;

	// up to two tokens from one scanned item, slot 0 first
	typedef struct packed {
		logic v0;
		logic v1;
		tok_t t0;
		tok_t t1;
	} tok_pair_t;

	typedef struct packed {
		logic       hit;
		logic [3:0] idx;
	} lookup_t;

	function automatic lookup_t punct_lookup(input logic [7:0] b);
		lookup_t r;
		r.hit = 1'b1;
		r.idx = 4'd0;
		unique case (b)
			8'h28: r.idx = 4'd0;  // (
			8'h29: r.idx = 4'd1;  // )
			8'h7B: r.idx = 4'd2;  // {
			8'h7D: r.idx = 4'd3;  // }
			8'h5B: r.idx = 4'd4;  // [
			8'h5D: r.idx = 4'd5;  // ]
			8'h3A: r.idx = 4'd6;  // :
			8'h3B: r.idx = 4'd7;  // ;
			8'h2C: r.idx = 4'd8;  // ,
			default: r.hit = 1'b0;
		endcase
		return r;
	endfunction

	function automatic lookup_t op_lookup(input logic [7:0] b);
		lookup_t r;
		r.hit = 1'b1;
		r.idx = 4'd0;
		unique case (b)
			8'h3D: r.idx = 4'd0;   // =
			8'h21: r.idx = 4'd1;   // !
			8'h2B: r.idx = 4'd2;   // +
			8'h2D: r.idx = 4'd3;   // -
			8'h2A: r.idx = 4'd4;   // *
			8'h2F: r.idx = 4'd5;   // /
			8'h25: r.idx = 4'd6;   // %
			8'h3C: r.idx = 4'd7;   // <
			8'h3E: r.idx = 4'd8;   // >
			8'h26: r.idx = 4'd9;   // &
			8'h7C: r.idx = 4'd10;  // |
			default: r.hit = 1'b0;
		endcase
		return r;
	endfunction

endpackage

[src/stt_scan.sv]
// scanner state and per-byte token logic of the source text tokenizer
module stt_scan #(
	parameter int OFFSET_BITS     = 24,
	parameter int KEYWORD_MAX_LEN = 6
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           fire,
	input  logic                           req_end,
	input  logic [7:0]                     src,
	input  logic [stt_pkg::LINE_BITS-1:0]  first_line,
	output stt_pkg::tok_pair_t             toks
);
	import stt_pkg::*;

	localparam int PW = 8 * KEYWORD_MAX_LEN;
	localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};
	localparam logic [OFFSET_BITS-1:0] POS_ONE = OFFSET_BITS'(1);

	mode_t                  mode_q, mode_d;
	logic [3:0]             op_q, op_d;
	logic [OFFSET_BITS-1:0] start_q, start_d;
	logic [OFFSET_BITS-1:0] pos_q, pos_d;
	logic [LINE_BITS-1:0]   line_q;
	logic [PW-1:0]          prefix_q, prefix_d;
	logic                   line_inc;

	logic                   is_digit, is_wstart, is_space, is_lf;
	lookup_t                punct_lk, op_lk;
	logic [OFFSET_BITS-1:0] dot_pos, tok_span;
	logic [KIND_BITS-1:0]   word_kind;

	mode_t                  id_mode;
	logic                   id_mark, id_word, id_line, id_v;
	tok_t                   id_tok;

	logic                   pre_v, post_v, take_idle, finish;
	tok_t                   pre_t, post_t;

	function automatic logic [FIELD_BITS-1:0] to_field(input logic [OFFSET_BITS-1:0] x);
		logic [OFFSET_BITS+FIELD_BITS-1:0] w;
		w = {{FIELD_BITS{1'b0}}, x};
		return w[FIELD_BITS-1:0];
	endfunction

	function automatic tok_t mk_tok(input logic [KIND_BITS-1:0] kind,
			input logic [OFFSET_BITS-1:0] start, input logic [OFFSET_BITS-1:0] len,
			input logic last, input logic [LINE_BITS-1:0] line);
		tok_t t;
		t.kind  = kind;
		t.start = to_field(start);
		t.len   = to_field(len);
		t.line  = line;
		t.last  = last;
		return t;
	endfunction

	// character classes
	assign is_digit  = (src >= CH_0) && (src <= CH_9);
	assign is_wstart = ((src >= CH_LA) && (src <= CH_LZ)) || ((src >= CH_UA) && (src <= CH_UZ))
		|| (src == CH_USCORE);
	assign is_space  = (src == CH_SPACE) || (src == CH_CR);
	assign is_lf     = (src == CH_LF);
	assign punct_lk  = punct_lookup(src);
	assign op_lk     = op_lookup(src);

	// span of the open token and position of a trailing dot
	assign tok_span = (pos_q > start_q) ? pos_q - start_q : '0;
	assign dot_pos  = (pos_q != '0) ? pos_q - POS_ONE : '0;

	// keyword match on the last characters of a word
	always_comb begin
		word_kind = KIND_IDENT;
		for (int i = 0; i < NUM_KW; i++) begin
			if ((tok_span == OFFSET_BITS'(KW_LEN[i])) && (prefix_q == PW'(KW_TEXT[i])))
				word_kind = KW_KIND[i];
		end
	end

	// byte seen between tokens
	always_comb begin
		id_mode = MODE_IDLE;
		id_mark = 1'b0;
		id_word = 1'b0;
		id_line = 1'b0;
		id_v    = 1'b0;
		id_tok  = mk_tok(KIND_ERROR, pos_q, POS_ONE, 1'b1, line_q);
		priority if (is_space) begin
			id_mode = MODE_IDLE;
		end else if (is_lf) begin
			id_line = 1'b1;
		end else if (punct_lk.hit) begin
			id_v   = 1'b1;
			id_tok = mk_tok({2'b00, punct_lk.idx}, pos_q, POS_ONE, 1'b0, line_q);
		end else if (op_lk.hit) begin
			id_mode = MODE_OP;
			id_mark = 1'b1;
		end else if (is_digit) begin
			id_mode = MODE_INT;
			id_mark = 1'b1;
		end else if (is_wstart) begin
			id_mode = MODE_WORD;
			id_mark = 1'b1;
			id_word = 1'b1;
		end else begin
			id_mode = MODE_HALT;
			id_v    = 1'b1;
		end
	end

	// next state and emitted tokens
	always_comb begin
		mode_d    = mode_q;
		op_d      = op_q;
		start_d   = start_q;
		prefix_d  = prefix_q;
		pos_d     = (pos_q < POS_MAX) ? pos_q + POS_ONE : pos_q;
		line_inc  = 1'b0;
		pre_v     = 1'b0;
		post_v    = 1'b0;
		pre_t     = mk_tok(KIND_ERROR, start_q, POS_ONE, 1'b1, line_q);
		post_t    = mk_tok(KIND_END, pos_q, '0, 1'b1, line_q);
		take_idle = 1'b0;
		finish    = 1'b1;
		if (req_end) begin
			unique case (mode_q)
				MODE_OP: begin
					pre_v = 1'b1;
					if (op_q < OP_EQ_FORMS) begin
						pre_t = mk_tok(KIND_OP_BASE + {1'b0, op_q, 1'b0}, start_q, POS_ONE,
							1'b0, line_q);
					end else begin
						finish = 1'b0;
					end
				end
				MODE_INT, MODE_FRAC: begin
					pre_v = 1'b1;
					pre_t = mk_tok(KIND_NUMBER, start_q, tok_span, 1'b0, line_q);
				end
				MODE_DOT: begin
					pre_v  = 1'b1;
					pre_t  = mk_tok(KIND_NUMBER, start_q,
						(dot_pos > start_q) ? dot_pos - start_q : '0, 1'b0, line_q);
					post_t = mk_tok(KIND_ERROR, dot_pos, POS_ONE, 1'b1, line_q);
					finish = 1'b0;
					post_v = 1'b1;
				end
				MODE_WORD: begin
					pre_v = 1'b1;
					pre_t = mk_tok(word_kind, start_q, tok_span, 1'b0, line_q);
				end
				MODE_HALT: finish = 1'b0;
				default: ;
			endcase
			if (finish)
				post_v = 1'b1;
			mode_d   = MODE_IDLE;
			op_d     = OP_NONE;
			start_d  = '0;
			prefix_d = '0;
			pos_d    = '0;
		end else begin
			unique case (mode_q)
				MODE_IDLE: take_idle = 1'b1;
				MODE_OP: begin
					priority if ((op_q < OP_EQ_FORMS) && (src == CH_EQ)) begin
						pre_v  = 1'b1;
						pre_t  = mk_tok(KIND_OPEQ_BASE + {1'b0, op_q, 1'b0}, start_q,
							tok_span + POS_ONE, 1'b0, line_q);
						mode_d = MODE_IDLE;
					end else if ((op_q == OP_SLASH) && (src == CH_SLASH)) begin
						mode_d = MODE_COMMENT;
					end else if ((op_q == OP_AMP) && (src == CH_AMP)) begin
						pre_v  = 1'b1;
						pre_t  = mk_tok(KIND_AND, start_q, tok_span + POS_ONE, 1'b0, line_q);
						mode_d = MODE_IDLE;
					end else if ((op_q == OP_PIPE) && (src == CH_PIPE)) begin
						pre_v  = 1'b1;
						pre_t  = mk_tok(KIND_OR, start_q, tok_span + POS_ONE, 1'b0, line_q);
						mode_d = MODE_IDLE;
					end else if (op_q >= OP_EQ_FORMS) begin
						pre_v  = 1'b1;
						mode_d = MODE_HALT;
					end else begin
						pre_v     = 1'b1;
						pre_t     = mk_tok(KIND_OP_BASE + {1'b0, op_q, 1'b0}, start_q, POS_ONE,
							1'b0, line_q);
						take_idle = 1'b1;
					end
				end
				MODE_INT, MODE_FRAC: begin
					if (is_digit) begin
						mode_d = mode_q;
					end else if ((mode_q == MODE_INT) && (src == CH_DOT)) begin
						mode_d = MODE_DOT;
					end else begin
						pre_v     = 1'b1;
						pre_t     = mk_tok(KIND_NUMBER, start_q, tok_span, 1'b0, line_q);
						take_idle = 1'b1;
					end
				end
				MODE_DOT: begin
					if (is_digit) begin
						mode_d = MODE_FRAC;
					end else begin
						pre_v  = 1'b1;
						pre_t  = mk_tok(KIND_NUMBER, start_q,
							(dot_pos > start_q) ? dot_pos - start_q : '0, 1'b0, line_q);
						post_v = 1'b1;
						post_t = mk_tok(KIND_ERROR, dot_pos, POS_ONE, 1'b1, line_q);
						mode_d = MODE_HALT;
					end
				end
				MODE_WORD: begin
					if (is_wstart || is_digit) begin
						prefix_d = {prefix_q[PW-9:0], src};
					end else begin
						pre_v     = 1'b1;
						pre_t     = mk_tok(word_kind, start_q, tok_span, 1'b0, line_q);
						take_idle = 1'b1;
					end
				end
				MODE_COMMENT: begin
					if (is_lf) begin
						line_inc = 1'b1;
						mode_d   = MODE_IDLE;
					end
				end
				MODE_HALT: mode_d = MODE_HALT;
				default: mode_d = MODE_IDLE;
			endcase
			// byte handled as the first of a new token
			if (take_idle) begin
				mode_d   = id_mode;
				line_inc = id_line;
				post_v   = id_v;
				post_t   = id_tok;
				if (id_mark)
					start_d = pos_q;
				if (id_mode == MODE_OP)
					op_d = op_lk.idx;
				if (id_word)
					prefix_d = PW'(src);
			end
		end
	end

	// pack tokens, earliest first
	always_comb begin
		toks.v0 = pre_v || post_v;
		toks.t0 = pre_v ? pre_t : post_t;
		toks.v1 = pre_v && post_v;
		toks.t1 = post_t;
	end

	// scanner registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			op_q     <= OP_NONE;
			start_q  <= '0;
			pos_q    <= '0;
			line_q   <= LINE_RESET;
			prefix_q <= '0;
		end else if (fire) begin
			mode_q   <= mode_d;
			op_q     <= op_d;
			start_q  <= start_d;
			pos_q    <= pos_d;
			prefix_q <= prefix_d;
			if (req_end)
				line_q <= first_line;
			else if (line_inc && (line_q != LINE_MAX))
				line_q <= line_q + 24'd1;
		end
	end

endmodule

[src/stt_outq.sv]
// small output queue that takes up to two token words per cycle
module stt_outq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  stt_pkg::tok_pair_t pair,
	output logic               room,
	output logic               out_valid,
	input  logic               out_ready,
	output stt_pkg::tok_t      out_tok
);
	import stt_pkg::*;

	localparam int PTRW = $clog2(OUTQ_DEPTH);
	localparam int CNTW = PTRW + 1;

	tok_t            mem [OUTQ_DEPTH];
	logic [PTRW-1:0] wr_q, rd_q;
	logic [CNTW-1:0] cnt_q;
	logic            push0, push1, pop;
	logic [1:0]      n_push;

	assign push0  = push && pair.v0;
	assign push1  = push && pair.v1;
	assign n_push = {1'b0, push0} + {1'b0, push1};
	assign pop    = out_valid && out_ready;

	assign room      = (cnt_q <= CNTW'(OUTQ_DEPTH - 2));
	assign out_valid = (cnt_q != '0);
	assign out_tok   = mem[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push0)
			mem[wr_q] <= pair.t0;
		if (push1)
			mem[wr_q + PTRW'(1)] <= pair.t1;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PTRW'(n_push);
			if (pop)
				rd_q <= rd_q + PTRW'(1);
			cnt_q <= cnt_q + CNTW'(n_push) - CNTW'(pop);
		end
	end

endmodule

[src/source_text_tokenizer.sv]
// top level of the streaming source text tokenizer
//
//  channel  direction  handshake            payload
//  s_       in         s_tvalid/s_tready    tdata: source_byte; tuser: req_type
//  m_       out        m_tvalid/m_tready    tdata: start, length, line; tuser: kind; tlast
//  cfg_     in         cfg_valid/cfg_ready  cfg_data: first_line_number
//
// one source byte per cycle; a word enters the input register and is scanned
// once the output queue has room; its zero to two tokens go into that four-word queue.
// the input stalls only while that queue holds more than two words.
// reset returns to idle with positions at zero and the line counter at one.
// a first_line_number write is taken at the next end marker.
module source_text_tokenizer #(
	parameter int OFFSET_BITS     = 24,
	parameter int KEYWORD_MAX_LEN = 6
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [7:0]                         s_tdata,   // [7:0] source_byte
	input  logic [0:0]                         s_tuser,   // [0] req_type
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [71:0]                        m_tdata,   // [23:0] start_offset,
	                                                      // [47:24] token_length,
	                                                      // [71:48] line_number
	output logic [stt_pkg::KIND_BITS-1:0]      m_tuser,   // [5:0] token_kind
	output logic                               m_tlast,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [stt_pkg::LINE_BITS-1:0]      cfg_data
);
	import stt_pkg::*;

	logic                 v_s1, end_s1;
	logic [7:0]           byte_s1;
	logic                 fire, room;
	logic [LINE_BITS-1:0] first_line_q;
	tok_pair_t            toks;
	tok_t                 head;

	// configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			first_line_q <= LINE_RESET;
		else if (cfg_valid)
			first_line_q <= cfg_data;
	end

	// input register
	assign fire     = v_s1 && room;
	assign s_tready = !v_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (s_tready)
			v_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			end_s1  <= s_tuser[0];
			byte_s1 <= s_tdata;
		end
	end

	stt_scan #(
		.OFFSET_BITS     (OFFSET_BITS),
		.KEYWORD_MAX_LEN (KEYWORD_MAX_LEN)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.req_end    (end_s1),
		.src        (byte_s1),
		.first_line (first_line_q),
		.toks       (toks)
	);

	stt_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire),
		.pair      (toks),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_tok   (head)
	);

	// result word
	assign m_tdata = {head.line, head.len, head.start};
	assign m_tuser = head.kind;
	assign m_tlast = head.last;

endmodule

[src/stt_checker.sv]
// port checker for the source text tokenizer and its bind
`include "source_text_tokenizer_macros.svh"

module stt_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [71:0]                   m_tdata,
	input logic [stt_pkg::KIND_BITS-1:0] m_tuser,
	input logic                          m_tlast
);
	import stt_pkg::*;

	// a stalled result word holds
	`STT_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
		"result word changed while stalled")

	// input back-pressure only comes from a backed-up output
	`STT_ASSERT_IMP(a_stall_cause, clk, arst_n, s_tvalid && !s_tready, m_tvalid,
		"input stalled with empty output")

	// error words close the source with a one-byte length
	`STT_ASSERT_IMP(a_error_word, clk, arst_n, m_tvalid && (m_tuser == KIND_ERROR),
		m_tlast && (m_tdata[47:24] == 24'd1), "bad error word")

	// end words close the source with zero length
	`STT_ASSERT_IMP(a_end_word, clk, arst_n, m_tvalid && (m_tuser == KIND_END),
		m_tlast && (m_tdata[47:24] == 24'd0), "bad end word")

	// only end and error words carry tlast
	`STT_ASSERT_IMP(a_last_kind, clk, arst_n, m_tvalid && m_tlast,
		(m_tuser == KIND_END) || (m_tuser == KIND_ERROR), "tlast on ordinary token")

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

[test/source_text_tokenizer_tb.sv]
// self-checking testbench for the streaming source text tokenizer
module source_text_tokenizer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import stt_pkg::*;

	localparam int          LIMIT_CYCLES = 200000;
	localparam int          DRAIN_CYCLES = 16;
	localparam int          PHASE_ITEMS  = 100;
	localparam int          WORD_KEEP    = 6;
	localparam logic [23:0] POS_MAX      = 24'hFFFFFF;
	localparam string       PUNCT_TEXT   = "(){}[]:;,";
	localparam string       OP_TEXT      = "=!+-*/%<>&|";
	localparam string       ALPHA        = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";

	typedef struct packed {
		logic       eos;
		logic [7:0] ch;
	} src_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic [0:0]  s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic [KIND_BITS-1:0] m_tuser;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [LINE_BITS-1:0] cfg_data = '0;

	src_word_t source_items[$];
	tok_t      pending_tokens[$];
	int        queued_count = 0;
	int        fault_count = 0;
	int        cycle_count = 0;
	logic      no_gaps = 1'b0;

	// scanner state as the testbench sees it
	mode_t       scan_mode_q = MODE_IDLE;
	logic [3:0]  held_op = OP_NONE;
	logic [23:0] tok_start = '0;
	logic [23:0] byte_pos = '0;
	logic [23:0] line_cnt = LINE_RESET;
	logic [23:0] first_line = LINE_RESET;
	logic [47:0] word_tail = '0;

	source_text_tokenizer u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),   // [7:0] source_byte
		.s_tuser(s_tuser),   // [0] req_type
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),   // [23:0] start_offset, [47:24] token_length, [71:48] line_number
		.m_tuser(m_tuser),   // [5:0] token_kind
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ---------------------------------------------------------------- prediction

	function automatic void note_token(input logic [KIND_BITS-1:0] kind, input logic [23:0] start,
			input logic [23:0] len, input logic last);
		tok_t t;
		t.kind  = kind;
		t.start = start;
		t.len   = len;
		t.line  = line_cnt;
		t.last  = last;
		pending_tokens.insert(pending_tokens.size(), t);
	endfunction

	function automatic logic [23:0] gap(input logic [23:0] from, input logic [23:0] to);
		return (to > from) ? to - from : 24'd0;
	endfunction

	function automatic logic is_digit(input logic [7:0] ch);
		return ch >= CH_0 && ch <= CH_9;
	endfunction

	function automatic logic is_word_start(input logic [7:0] ch);
		return (ch >= CH_LA && ch <= CH_LZ) || (ch >= CH_UA && ch <= CH_UZ) || ch == CH_USCORE;
	endfunction

	function automatic void bump_line();
		if (line_cnt != LINE_MAX) line_cnt++;
	endfunction

	function automatic void fail_at(input logic [23:0] start);
		note_token(KIND_ERROR, start, 24'd1, 1'b1);
		scan_mode_q = MODE_HALT;
	endfunction

	// identifier or keyword; long words are never keywords
	function automatic void close_word(input logic [23:0] p);
		logic [23:0]          len;
		logic [KIND_BITS-1:0] kind;
		len  = gap(tok_start, p);
		kind = KIND_IDENT;
		if (len <= 24'(WORD_KEEP)) begin
			case (word_tail)
				48'("fn"):     if (len == 24'd2) kind = KIND_FN;
				48'("let"):    if (len == 24'd3) kind = KIND_LET;
				48'("mut"):    if (len == 24'd3) kind = KIND_MUT;
				48'("return"): if (len == 24'd6) kind = KIND_RETURN;
				48'("true"):   if (len == 24'd4) kind = KIND_BOOL;
				48'("false"):  if (len == 24'd5) kind = KIND_BOOL;
				default:       kind = KIND_IDENT;
			endcase
		end
		note_token(kind, tok_start, len, 1'b0);
	endfunction

	// number closed by a dot with no digit, error at the dot
	function automatic void dot_fail(input logic [23:0] p);
		logic [23:0] dot;
		dot = (p > 24'd0) ? p - 24'd1 : 24'd0;
		note_token(KIND_NUMBER, tok_start, gap(tok_start, dot), 1'b0);
		fail_at(dot);
	endfunction

	// byte seen between tokens
	function automatic void open_token(input logic [7:0] ch, input logic [23:0] p);
		int i;
		scan_mode_q = MODE_IDLE;
		if (ch == CH_SPACE || ch == CH_CR) return;
		if (ch == CH_LF) begin
			bump_line();
			return;
		end
		for (i = 0; i < PUNCT_TEXT.len(); i++) begin
			if (ch == PUNCT_TEXT[i]) begin
				note_token(KIND_BITS'(i), p, 24'd1, 1'b0);
				return;
			end
		end
		for (i = 0; i < OP_TEXT.len(); i++) begin
			if (ch == OP_TEXT[i]) begin
				scan_mode_q = MODE_OP;
				held_op = 4'(i);
				tok_start = p;
				return;
			end
		end
		if (is_digit(ch)) begin
			scan_mode_q = MODE_INT;
			tok_start = p;
		end else if (is_word_start(ch)) begin
			scan_mode_q = MODE_WORD;
			tok_start = p;
			word_tail = {40'd0, ch};
		end else begin
			fail_at(p);
		end
	endfunction

	// second byte after an operator character
	function automatic void after_op(input logic [7:0] ch, input logic [23:0] p);
		logic [KIND_BITS-1:0] twice;
		twice = {1'b0, held_op, 1'b0};
		if (held_op < OP_AMP && ch == CH_EQ) begin
			note_token(KIND_OPEQ_BASE + twice, tok_start, gap(tok_start, p) + 24'd1, 1'b0);
			scan_mode_q = MODE_IDLE;
		end else if (held_op == OP_SLASH && ch == CH_SLASH) begin
			scan_mode_q = MODE_COMMENT;
		end else if (held_op == OP_AMP && ch == CH_AMP) begin
			note_token(KIND_AND, tok_start, gap(tok_start, p) + 24'd1, 1'b0);
			scan_mode_q = MODE_IDLE;
		end else if (held_op == OP_PIPE && ch == CH_PIPE) begin
			note_token(KIND_OR, tok_start, gap(tok_start, p) + 24'd1, 1'b0);
			scan_mode_q = MODE_IDLE;
		end else if (held_op >= OP_AMP) begin
			fail_at(tok_start);
		end else begin
			note_token(KIND_OP_BASE + twice, tok_start, 24'd1, 1'b0);
			open_token(ch, p);
		end
	endfunction

	// end marker: flush, close with end unless failed, then restart
	function automatic void close_source();
		logic [23:0] p;
		logic        closed;
		p = byte_pos;
		closed = 1'b1;
		case (scan_mode_q)
			MODE_OP: begin
				if (held_op < OP_AMP) begin
					note_token(KIND_OP_BASE + {1'b0, held_op, 1'b0}, tok_start, 24'd1, 1'b0);
				end else begin
					fail_at(tok_start);
					closed = 1'b0;
				end
			end
			MODE_INT, MODE_FRAC: note_token(KIND_NUMBER, tok_start, gap(tok_start, p), 1'b0);
			MODE_DOT: begin
				dot_fail(p);
				closed = 1'b0;
			end
			MODE_WORD: close_word(p);
			MODE_HALT: closed = 1'b0;
			default: ;
		endcase
		if (closed) note_token(KIND_END, p, 24'd0, 1'b1);
		scan_mode_q = MODE_IDLE;
		held_op = OP_NONE;
		tok_start = '0;
		byte_pos = '0;
		line_cnt = first_line;
		word_tail = '0;
	endfunction

	// one accepted word: expected tokens go to pending_tokens
	function automatic void lex_item(input logic eos, input logic [7:0] ch);
		logic [23:0] p;
		p = byte_pos;
		if (eos) begin
			close_source();
			return;
		end
		case (scan_mode_q)
			MODE_IDLE: open_token(ch, p);
			MODE_OP: after_op(ch, p);
			MODE_INT, MODE_FRAC: begin
				if (scan_mode_q == MODE_INT && ch == CH_DOT) begin
					scan_mode_q = MODE_DOT;
				end else if (!is_digit(ch)) begin
					note_token(KIND_NUMBER, tok_start, gap(tok_start, p), 1'b0);
					open_token(ch, p);
				end
			end
			MODE_DOT: begin
				if (is_digit(ch)) scan_mode_q = MODE_FRAC;
				else dot_fail(p);
			end
			MODE_WORD: begin
				if (is_word_start(ch) || is_digit(ch)) begin
					word_tail = {word_tail[39:0], ch};
				end else begin
					close_word(p);
					open_token(ch, p);
				end
			end
			MODE_COMMENT: begin
				if (ch == CH_LF) begin
					bump_line();
					scan_mode_q = MODE_IDLE;
				end
			end
			default: ;
		endcase
		if (byte_pos != POS_MAX) byte_pos++;
	endfunction

	// ---------------------------------------------------------------- driver and monitor

	// input side: hold a word until taken, otherwise gap at random
	always @(posedge clk) begin : feed
		logic      drive;
		src_word_t head;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				head = source_items.pop_front();
				lex_item(head.eos, head.ch);
			end
			drive = 1'b0;
			if (s_tvalid && !s_tready) drive = 1'b1;
			else if (source_items.size() != 0) drive = no_gaps || $urandom_range(0, 99) >= 30;
			if (drive) begin
				head = source_items[0];
				s_tdata <= head.ch;
				s_tuser <= head.eos;
			end
			s_tvalid <= drive;
		end
	end

	function automatic void note_fault(input string msg);
		fault_count++;
		if (fault_count <= 10) $display("%s", msg);
	endfunction

	// output side: check each word against the oldest expected token
	always @(posedge clk) begin : drain
		tok_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_tokens.size() == 0) begin
					note_fault($sformatf("unexpected token: kind %0d start %0d len %0d line %0d last %0b",
						m_tuser, m_tdata[23:0], m_tdata[47:24], m_tdata[71:48], m_tlast));
				end else begin
					want = pending_tokens.pop_front();
					if (m_tuser !== want.kind || m_tdata[23:0] !== want.start ||
							m_tdata[47:24] !== want.len || m_tdata[71:48] !== want.line ||
							m_tlast !== want.last)
						note_fault($sformatf({"token mismatch: expected kind %0d start %0d len %0d",
							" line %0d last %0b, got kind %0d start %0d len %0d line %0d last %0b"},
							want.kind, want.start, want.len, want.line, want.last,
							m_tuser, m_tdata[23:0], m_tdata[47:24], m_tdata[71:48], m_tlast));
				end
			end
			m_tready <= no_gaps || $urandom_range(0, 99) >= 30;
		end
	end

	// ---------------------------------------------------------------- stimulus

	function automatic void add_item(input logic eos, input logic [7:0] ch);
		src_word_t w;
		w.eos = eos;
		w.ch  = ch;
		source_items.insert(source_items.size(), w);
		queued_count++;
	endfunction

	function automatic void add_byte(input logic [7:0] ch);
		add_item(1'b0, ch);
	endfunction

	function automatic void add_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++) add_byte(s[i]);
	endfunction

	function automatic void add_end();
		add_item(1'b1, 8'($urandom_range(0, 255)));
	endfunction

	function automatic string keyword_text(input int i);
		case (i)
			0: return "fn";
			1: return "let";
			2: return "mut";
			3: return "return";
			4: return "true";
			default: return "false";
		endcase
	endfunction

	function automatic void add_digits(input int n);
		int i;
		for (i = 0; i < n; i++) add_byte(8'(CH_0 + $urandom_range(0, 9)));
	endfunction

	// one well-formed token, line comment, newline or blank with random content
	function automatic void add_token();
		int i;
		int k;
		case ($urandom_range(0, 9))
			0: add_byte(PUNCT_TEXT[$urandom_range(0, 8)]);
			1, 2: begin
				k = $urandom_range(0, 10);
				add_byte(OP_TEXT[k]);
				if (k >= OP_AMP) add_byte(OP_TEXT[k]);
				else if ($urandom_range(0, 1)) add_byte(CH_EQ);
			end
			3, 4: begin
				add_digits($urandom_range(1, 4));
				if ($urandom_range(0, 2) == 0) begin
					add_byte(CH_DOT);
					add_digits($urandom_range(1, 3));
				end
			end
			5: begin
				// keyword, sometimes stretched into a plain identifier
				if ($urandom_range(0, 4) == 0) add_byte(ALPHA[$urandom_range(0, 52)]);
				add_text(keyword_text($urandom_range(0, 5)));
				if ($urandom_range(0, 4) == 0) add_byte(ALPHA[$urandom_range(0, 52)]);
			end
			6: begin
				add_byte(ALPHA[$urandom_range(0, 52)]);
				for (i = $urandom_range(0, 8); i > 0; i--)
					add_byte($urandom_range(0, 3) == 0 ? 8'(CH_0 + $urandom_range(0, 9))
						: ALPHA[$urandom_range(0, 52)]);
			end
			7: begin
				// line comment with any bytes but a newline
				add_byte(CH_SLASH);
				add_byte(CH_SLASH);
				for (i = $urandom_range(0, 6); i > 0; i--) begin
					k = $urandom_range(0, 255);
					add_byte(k == CH_LF ? CH_SPACE : 8'(k));
				end
				add_byte(CH_LF);
			end
			8: add_byte(CH_LF);
			default: add_byte($urandom_range(0, 1) ? CH_SPACE : CH_CR);
		endcase
	endfunction

	// a source of random tokens, an occasional bad byte or broken tail, then the end marker
	function automatic void add_random_source();
		int budget;
		int origin;
		budget = $urandom_range(0, 30);
		origin = queued_count;
		while (queued_count - origin < budget) begin
			add_token();
			case ($urandom_range(0, 5))
				0: add_byte(CH_SPACE);
				1: add_byte(CH_LF);
				2: add_byte(CH_CR);
				default: ;
			endcase
			if ($urandom_range(0, 29) == 0) add_byte(8'($urandom_range(0, 255)));
		end
		case ($urandom_range(0, 15))
			0: add_text("1.");
			1: add_byte(CH_AMP);
			2: add_byte(CH_PIPE);
			3: add_text("4.=");
			4: add_text("&+");
			default: ;
		endcase
		add_end();
	endfunction

	function automatic void fill_phase();
		int target;
		target = queued_count + PHASE_ITEMS;
		while (queued_count < target) add_random_source();
	endfunction

	// wait until no word is pending anywhere, then let the block settle
	task automatic wait_drained();
		while (source_items.size() != 0 || s_tvalid || pending_tokens.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_first_line(input logic [LINE_BITS-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		first_line = value;
	endtask

	// run limit
	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("source_text_tokenizer_tb NOT OK");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: operator with '=', fraction, byte after number ends it
		add_text("a+=1.5;");
		add_end();
		// dot with no digit, then ignored bytes and an end with no token
		add_text("1.)");
		add_end();
		// lone ampersand
		add_text("&x");
		add_end();
		// a byte outside ascii and a null byte
		add_byte(8'hFF);
		add_end();
		add_byte(8'h00);
		add_end();
		// keyword closed by the end marker
		add_text("true");
		add_end();
		fill_phase();

		// further phases under other line settings; one runs without gaps
		for (int phase = 1; phase <= 4; phase++) begin
			wait_drained();
			case (phase)
				1: write_first_line(24'hFFFFFE);
				2: write_first_line(24'h000000);
				3: write_first_line(24'($urandom));
				default: write_first_line(LINE_MAX);
			endcase
			no_gaps = (phase == 2);
			fill_phase();
		end

		wait_drained();
		if (fault_count == 0 && pending_tokens.size() == 0) begin
			$display("source_text_tokenizer_tb OK");
		end else begin
			$display("source_text_tokenizer_tb NOT OK");
		end
		$finish;
	end

endmodule
